// ----- sv/ecpr_pkg.sv -----
// Shared types and constants for the enhanced clock page replacement unit.
// Depends on nothing; the top level imports it.
`default_nettype none

package ecpr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 20;
	localparam int KIND_W        = 2;
	localparam int CODE_W        = 3;
	localparam int SLOT_W        = 4;

	// Input kinds.
	localparam logic [KIND_W-1:0] K_INSERT    = 2'd0;
	localparam logic [KIND_W-1:0] K_REFERENCE = 2'd1;
	localparam logic [KIND_W-1:0] K_VICTIM    = 2'd2;

	// Result codes.
	localparam logic [CODE_W-1:0] RC_INSERTED   = 3'd0;
	localparam logic [CODE_W-1:0] RC_REFERENCED = 3'd1;
	localparam logic [CODE_W-1:0] RC_WRITEBACK  = 3'd2;
	localparam logic [CODE_W-1:0] RC_VICTIM     = 3'd3;
	localparam logic [CODE_W-1:0] RC_FULL       = 3'd4;
	localparam logic [CODE_W-1:0] RC_EMPTY      = 3'd5;
	localparam logic [CODE_W-1:0] RC_NOT_FOUND  = 3'd6;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_SCAN = 7'b0000010,
		S_REF_SCAN = 7'b0000100,
		S_REF_CMP  = 7'b0001000,
		S_VIC_SCAN = 7'b0010000,
		S_VIC_EMIT = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

// ----- sv/enhanced_clock_page_replacement_unit.sv -----
// Enhanced second-chance clock page replacement over a ring of page frames.
// Depends on ecpr_pkg for kinds, result codes and the sequencer state type.
//
// Usage: the input channel (in_valid/in_stall) carries one request beat of
// kind, page_number and is_write; the output channel (out_valid/out_stall)
// carries result beats of result_code, page_number_res, slot and last.
// One request is worked at a time; in_stall is high until its final result
// beat has been loaded into the output register. A sequencer walks the ring
// slot by slot through a single page memory port and one comparator.
// Work per request kind:
//   insert:    scan for an empty slot from the free pointer,
//   reference: a memory read and compare per valid slot, starting at slot 0,
//   victim:    a sweep from the hand up to the final beat.
// Full and empty requests give one result beat; unknown kinds give none.
// Reset clears all marks, the hand, the free pointer and the count at once;
// page memory contents are left as they are and are only read once written.
// A stalled output beat holds; the sequencer waits for the output register
// to free before loading the next beat, and no result is lost.
`default_nettype none

module enhanced_clock_page_replacement_unit #(
	parameter int FRAMES    = ecpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ecpr_pkg::KIND_W-1:0] kind,
	input  wire logic [PAGE_BITS-1:0]        page_number,
	input  wire logic                        is_write,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ecpr_pkg::CODE_W-1:0]      result_code,
	output logic [PAGE_BITS-1:0]             page_number_res,
	output logic [ecpr_pkg::SLOT_W-1:0]      slot,
	output logic                             last
);
	import ecpr_pkg::*;

	localparam int SW    = $clog2(FRAMES);
	localparam int CW    = $clog2(FRAMES + 1);
	localparam int EXT_W = SW + SLOT_W;
	localparam logic [SW-1:0] LAST_IDX = SW'(FRAMES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(FRAMES);

	state_t                state_q;
	logic [SW-1:0]         idx_q;
	logic [SW-1:0]         idx_nxt;
	logic [SW-1:0]         hand_q;
	logic [SW-1:0]         free_q;
	logic [CW-1:0]         count_q;
	logic [FRAMES-1:0]     valid_q;
	logic [FRAMES-1:0]     acc_q;
	logic [FRAMES-1:0]     dirty_q;
	logic [PAGE_BITS-1:0]  req_page_q;
	logic                  req_wr_q;
	logic [CODE_W-1:0]     res_code_q;
	logic [PAGE_BITS-1:0]  res_page_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  out_valid_q;
	logic [CODE_W-1:0]     out_code_q;
	logic [PAGE_BITS-1:0]  out_page_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic                  out_last_q;
	logic [PAGE_BITS-1:0]  page_mem [FRAMES];
	logic [PAGE_BITS-1:0]  rd_data_q;
	logic                  mem_we;
	logic                  mem_re;
	logic                  out_free;
	logic                  out_load;
	logic                  in_accept;
	logic [EXT_W-1:0]      idx_ext;
	logic [EXT_W-1:0]      hand_ext;

	assign idx_nxt   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign idx_ext   = EXT_W'(idx_q);
	assign hand_ext  = EXT_W'(hand_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && ((state_q == S_VIC_EMIT) || (state_q == S_RESP));
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && (state_q == S_IDLE);

	assign mem_we = (state_q == S_INS_SCAN) && !valid_q[idx_q];
	assign mem_re = ((state_q == S_REF_SCAN) && valid_q[idx_q]) ||
		((state_q == S_VIC_SCAN) && valid_q[idx_q] && !acc_q[idx_q]);

	// Page memory: one port, shared by insert writes and scan reads.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem[idx_q] <= req_page_q;
		end
		if (mem_re) begin
			rd_data_q <= page_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			hand_q      <= '0;
			free_q      <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			acc_q       <= '0;
			dirty_q     <= '0;
			req_page_q  <= '0;
			req_wr_q    <= 1'b0;
			res_code_q  <= RC_INSERTED;
			res_page_q  <= '0;
			res_slot_q  <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= RC_INSERTED;
			out_page_q  <= '0;
			out_slot_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_page_q <= page_number;
						req_wr_q   <= is_write;
						unique case (kind)
							K_INSERT: begin
								if (count_q == FULL_CNT) begin
									res_code_q <= RC_FULL;
									res_page_q <= page_number;
									res_slot_q <= hand_ext[SLOT_W-1:0];
									state_q    <= S_RESP;
								end else begin
									idx_q   <= free_q;
									state_q <= S_INS_SCAN;
								end
							end
							K_REFERENCE: begin
								idx_q   <= '0;
								state_q <= S_REF_SCAN;
							end
							K_VICTIM: begin
								if (count_q == '0) begin
									res_code_q <= RC_EMPTY;
									res_page_q <= '0;
									res_slot_q <= '0;
									state_q    <= S_RESP;
								end else begin
									idx_q   <= hand_q;
									state_q <= S_VIC_SCAN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INS_SCAN: begin
					// A free slot exists because the ring is not full.
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						acc_q[idx_q]   <= 1'b1;
						dirty_q[idx_q] <= req_wr_q;
						count_q        <= count_q + 1'b1;
						free_q         <= idx_nxt;
						res_code_q     <= RC_INSERTED;
						res_page_q     <= req_page_q;
						res_slot_q     <= idx_ext[SLOT_W-1:0];
						state_q        <= S_RESP;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				S_REF_SCAN: begin
					if (valid_q[idx_q]) begin
						state_q <= S_REF_CMP;
					end else if (idx_q == LAST_IDX) begin
						res_code_q <= RC_NOT_FOUND;
						res_page_q <= req_page_q;
						res_slot_q <= '0;
						state_q    <= S_RESP;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				S_REF_CMP: begin
					if (rd_data_q == req_page_q) begin
						acc_q[idx_q] <= 1'b1;
						if (req_wr_q) begin
							dirty_q[idx_q] <= 1'b1;
						end
						res_code_q <= RC_REFERENCED;
						res_page_q <= req_page_q;
						res_slot_q <= idx_ext[SLOT_W-1:0];
						state_q    <= S_RESP;
					end else if (idx_q == LAST_IDX) begin
						res_code_q <= RC_NOT_FOUND;
						res_page_q <= req_page_q;
						res_slot_q <= '0;
						state_q    <= S_RESP;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_REF_SCAN;
					end
				end
				S_VIC_SCAN: begin
					if (valid_q[idx_q] && !acc_q[idx_q]) begin
						state_q <= S_VIC_EMIT;
					end else begin
						if (valid_q[idx_q]) begin
							acc_q[idx_q] <= 1'b0;
						end
						idx_q <= idx_nxt;
					end
				end
				S_VIC_EMIT: begin
					if (out_free) begin
						out_page_q  <= rd_data_q;
						out_slot_q  <= idx_ext[SLOT_W-1:0];
						if (dirty_q[idx_q]) begin
							// Write back and give the page one more pass.
							out_code_q     <= RC_WRITEBACK;
							out_last_q     <= 1'b0;
							dirty_q[idx_q] <= 1'b0;
							idx_q          <= idx_nxt;
							state_q        <= S_VIC_SCAN;
						end else begin
							out_code_q     <= RC_VICTIM;
							out_last_q     <= 1'b1;
							valid_q[idx_q] <= 1'b0;
							count_q        <= count_q - 1'b1;
							free_q         <= idx_q;
							hand_q         <= idx_nxt;
							state_q        <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_code_q  <= res_code_q;
						out_page_q  <= res_page_q;
						out_slot_q  <= res_slot_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign result_code     = out_code_q;
	assign page_number_res = out_page_q;
	assign slot            = out_slot_q;
	assign last            = out_last_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("resident count disagrees with valid marks");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("resident count exceeds ring size");

	a_only_writeback_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> result_code == RC_WRITEBACK)
		else $error("non-final result beat is not a writeback");

	a_victim_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && kind == K_VICTIM && count_q != '0 |=> state_q == S_VIC_SCAN)
		else $error("victim request on a non-empty ring did not start a sweep");

endmodule

`default_nettype wire
